FILE: sv/rmta_pkg.sv
// ----------------------------------------------------------------------------
// rmta_pkg
// Shared constants, codes and helpers of the mapped region table allocator.
// ----------------------------------------------------------------------------
package rmta_pkg;

  localparam int DEPTH       = 32;
  localparam int IDX_W       = 5;
  localparam int CNT_W       = 6;
  localparam int MAX_REGIONS = 30;
  localparam int PAGE_BITS   = 12;
  localparam int START_W     = 32;
  localparam int LEN_W       = 31;
  localparam int ENTRY_W     = START_W + LEN_W;
  localparam int WIDE_W      = 34;

  localparam logic [WIDE_W-1:0] PG_MASK = WIDE_W'((64'd1 << PAGE_BITS) - 64'd1);

  localparam logic [31:0] BASE_RESET  = 32'h4000_0000;
  localparam logic [31:0] LIMIT_RESET = 32'h8000_0000;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_BADARG   = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_NOROOM   = 3'd3;
  localparam logic [2:0] ST_NOTFOUND = 3'd4;

  localparam logic CMD_MAP   = 1'b0;
  localparam logic CMD_UNMAP = 1'b1;

  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_LIMIT = 1'b1;

  typedef logic [WIDE_W-1:0] wide_t;

  function automatic wide_t pg_up(input wide_t a);
    return (a + PG_MASK) & ~PG_MASK;
  endfunction

endpackage

FILE: sv/mmap_region_table_allocator_unit.sv
// ----------------------------------------------------------------------------
// mmap_region_table_allocator_unit
// Address-sorted table of mapped regions with hint or first-fit placement and
// shift-based insert and remove, held in one table RAM.
// ----------------------------------------------------------------------------
//  channel   ports                         handshake
//  request   in_*                          start & !busy
//  result    out_*                         out_valid, one cycle
//  config    cfg_we, cfg_index, cfg_wdata  cfg_we
//
//  a request passes through the prep states and a check, then a scan of
//  the held regions up to the placement decision, then a fit check and,
//  if it passes, entry moves on insert, or entry moves on a full remove;
//  a map request that fails the check ends there; the result strobe is
//  registered; scan and moves share the single table RAM port pair
//  no clearing pass after reset; entries above the count are never used
//  results cannot be stalled
// ----------------------------------------------------------------------------
module mmap_region_table_allocator_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_cmd,
  input  logic [31:0] in_req_addr,
  input  logic [30:0] in_req_size,
  input  logic        in_map_shared,
  input  logic        in_map_private,
  input  logic        in_map_fixed,
  input  logic        in_prot_write,
  input  logic        in_file_writable,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [31:0] out_region_addr,
  output logic [4:0]  out_slot,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import rmta_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_PREP   = 4'd1;
  localparam logic [3:0] S_PREP2  = 4'd2;
  localparam logic [3:0] S_CHECK  = 4'd3;
  localparam logic [3:0] S_SCAN   = 4'd4;
  localparam logic [3:0] S_DECIDE = 4'd5;
  localparam logic [3:0] S_FIT    = 4'd6;
  localparam logic [3:0] S_SHUP   = 4'd7;
  localparam logic [3:0] S_SHDN   = 4'd8;

  logic [3:0]         state_r, state_nxt;
  logic [31:0]        base_r, limit_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               cmd_r, shared_r, priv_r, fixed_r, pw_r, fw_r;
  logic [31:0]        addr_r;
  logic [LEN_W-1:0]   size_r;
  wide_t              m_r, m_nxt, us_r, us_nxt, basepg_r, basepg_nxt;
  wide_t              msz_r, msz_nxt, bound_r, bound_nxt;
  logic [CNT_W-1:0]   k_r, k_nxt;
  logic [START_W-1:0] prev_start_r, prev_start_nxt;
  wide_t              prev_end_r, prev_end_nxt;
  logic               tat_done_r, tat_done_nxt, tat_found_r, tat_found_nxt;
  logic [IDX_W-1:0]   tat_slot_r, tat_slot_nxt;
  logic               ff_done_r, ff_done_nxt;
  logic [IDX_W-1:0]   ff_slot_r, ff_slot_nxt;
  wide_t              ff_addr_r, ff_addr_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [LEN_W-1:0]   hit_len_r, hit_len_nxt;
  wide_t              ins_addr_r, ins_addr_nxt;
  logic [IDX_W-1:0]   ins_slot_r, ins_slot_nxt;
  logic [CNT_W-1:0]   remain_r, remain_nxt;
  logic [IDX_W-1:0]   src_r, src_nxt, wtgt_r, wtgt_nxt;
  logic               rvalid_r, rvalid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_status_r, out_status_nxt;
  logic [31:0]        out_addr_r, out_addr_nxt;
  logic [IDX_W-1:0]   out_slot_r, out_slot_nxt;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr, ram_raddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [START_W-1:0] cur_start;
  logic [LEN_W-1:0]   cur_len;
  wide_t              cur_end, cur_e, ff_gap;
  logic [CNT_W-1:0]   n, j;
  logic               accept, use_hint, tat_hit, tat_ok, m_above;

  rmta_ram #(.WIDTH(ENTRY_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign busy            = (state_r != S_IDLE);
  assign accept          = start && !busy;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_region_addr = out_addr_r;
  assign out_slot        = out_slot_r;

  assign n         = count_r;
  assign j         = k_r - CNT_W'(1);
  assign cur_start = ram_rdata[ENTRY_W-1:LEN_W];
  assign cur_len   = ram_rdata[LEN_W-1:0];
  assign cur_end   = pg_up(WIDE_W'(cur_start) + WIDE_W'(cur_len));
  assign cur_e     = pg_up(WIDE_W'(cur_start));
  assign ff_gap    = cur_e - prev_end_r;
  assign use_hint  = (addr_r != 32'd0);
  assign m_above   = (m_r > prev_end_r);
  assign tat_hit   = (n != '0) && (m_above || (tat_done_r && tat_found_r));
  assign tat_ok    = use_hint && tat_hit && (bound_r < WIDE_W'(limit_r));

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    m_nxt          = m_r;
    us_nxt         = us_r;
    basepg_nxt     = basepg_r;
    msz_nxt        = msz_r;
    bound_nxt      = bound_r;
    k_nxt          = k_r;
    prev_start_nxt = prev_start_r;
    prev_end_nxt   = prev_end_r;
    tat_done_nxt   = tat_done_r;
    tat_found_nxt  = tat_found_r;
    tat_slot_nxt   = tat_slot_r;
    ff_done_nxt    = ff_done_r;
    ff_slot_nxt    = ff_slot_r;
    ff_addr_nxt    = ff_addr_r;
    hit_nxt        = hit_r;
    hit_idx_nxt    = hit_idx_r;
    hit_len_nxt    = hit_len_r;
    ins_addr_nxt   = ins_addr_r;
    ins_slot_nxt   = ins_slot_r;
    remain_nxt     = remain_r;
    src_nxt        = src_r;
    wtgt_nxt       = wtgt_r;
    rvalid_nxt     = 1'b0;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_addr_nxt   = out_addr_r;
    out_slot_nxt   = out_slot_r;
    ram_we         = 1'b0;
    ram_waddr      = wtgt_r;
    ram_wdata      = ram_rdata;
    ram_raddr      = src_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        m_nxt      = pg_up(WIDE_W'(addr_r));
        us_nxt     = pg_up(WIDE_W'(size_r));
        basepg_nxt = pg_up(WIDE_W'(base_r));
        state_nxt  = S_PREP2;
      end
      S_PREP2: begin
        msz_nxt   = m_r + WIDE_W'(size_r);
        state_nxt = S_CHECK;
      end
      S_CHECK: begin
        bound_nxt    = pg_up(msz_r);
        k_nxt        = '0;
        tat_done_nxt = 1'b0;
        tat_found_nxt = 1'b0;
        ff_done_nxt  = 1'b0;
        hit_nxt      = 1'b0;
        state_nxt    = (n == '0) ? S_DECIDE : S_SCAN;
        out_addr_nxt = 32'd0;
        out_slot_nxt = '0;
        if (cmd_r == CMD_MAP) begin
          out_valid_nxt  = 1'b1;
          state_nxt      = S_IDLE;
          if (!priv_r && !shared_r) begin
            out_status_nxt = ST_BADARG;
          end else if (count_r >= CNT_W'(MAX_REGIONS)) begin
            out_status_nxt = ST_FULL;
          end else if (shared_r && pw_r && !fw_r) begin
            out_status_nxt = ST_BADARG;
          end else if (fixed_r && ((addr_r == 32'd0) || (addr_r < base_r) ||
                       (pg_up(msz_r) > WIDE_W'(limit_r)) ||
                       (addr_r[PAGE_BITS-1:0] != '0))) begin
            out_status_nxt = ST_BADARG;
          end else if (!fixed_r && use_hint && ((addr_r < base_r) ||
                       (pg_up(msz_r) > WIDE_W'(limit_r)))) begin
            out_status_nxt = ST_BADARG;
          end else begin
            out_valid_nxt = 1'b0;
            state_nxt     = (n == '0) ? S_DECIDE : S_SCAN;
          end
        end
      end
      S_SCAN: begin
        ram_raddr = k_r[IDX_W-1:0];
        k_nxt     = k_r + CNT_W'(1);
        if (k_r != '0) begin
          prev_start_nxt = cur_start;
          prev_end_nxt   = cur_end;
          if (!hit_r && ({1'b0, cur_start} == m_r[START_W:0])
              && (m_r[WIDE_W-1:START_W+1] == '0)) begin
            hit_nxt     = 1'b1;
            hit_idx_nxt = j[IDX_W-1:0];
            hit_len_nxt = cur_len;
          end
          if (k_r >= CNT_W'(2)) begin
            if (!tat_done_r) begin
              if (WIDE_W'(prev_start_r) >= m_r) begin
                tat_done_nxt = 1'b1;
              end else if (m_r > prev_end_r && cur_e > msz_r) begin
                tat_done_nxt  = 1'b1;
                tat_found_nxt = 1'b1;
                tat_slot_nxt  = j[IDX_W-1:0];
              end
            end
            if (!ff_done_r && cur_e > prev_end_r && ff_gap > WIDE_W'(size_r)) begin
              ff_done_nxt = 1'b1;
              ff_slot_nxt = j[IDX_W-1:0];
              ff_addr_nxt = prev_end_r;
            end
          end
          if (k_r == n) begin
            state_nxt = S_DECIDE;
          end
        end
      end
      S_DECIDE: begin
        out_addr_nxt = 32'd0;
        out_slot_nxt = '0;
        if (cmd_r == CMD_UNMAP) begin
          state_nxt = S_IDLE;
          if (!hit_r || hit_len_r == '0) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_NOTFOUND;
          end else if (WIDE_W'(hit_len_r) <= us_r) begin
            remain_nxt = n - CNT_W'(1) - CNT_W'(hit_idx_r);
            src_nxt    = hit_idx_r + IDX_W'(1);
            out_slot_nxt = hit_idx_r;
            state_nxt  = S_SHDN;
          end else begin
            ram_we         = 1'b1;
            ram_waddr      = hit_idx_r;
            ram_wdata      = {m_r[START_W-1:0], hit_len_r - us_r[LEN_W-1:0]};
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_OK;
            out_slot_nxt   = hit_idx_r;
          end
        end else if (tat_ok) begin
          ins_addr_nxt = m_r;
          ins_slot_nxt = m_above ? n[IDX_W-1:0] : tat_slot_r;
          state_nxt    = S_FIT;
        end else if (fixed_r) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOROOM;
          state_nxt      = S_IDLE;
        end else begin
          if (n == '0) begin
            ins_addr_nxt = basepg_r;
            ins_slot_nxt = '0;
          end else if (ff_done_r) begin
            ins_addr_nxt = ff_addr_r;
            ins_slot_nxt = ff_slot_r;
          end else begin
            ins_addr_nxt = prev_end_r;
            ins_slot_nxt = n[IDX_W-1:0];
          end
          state_nxt = S_FIT;
        end
      end
      S_FIT: begin
        if (pg_up(ins_addr_r + WIDE_W'(size_r)) < WIDE_W'(limit_r)) begin
          remain_nxt = n - CNT_W'(ins_slot_r);
          src_nxt    = n[IDX_W-1:0] - IDX_W'(1);
          state_nxt  = S_SHUP;
        end else begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NOROOM;
          out_addr_nxt   = 32'd0;
          out_slot_nxt   = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_SHUP: begin
        if (remain_r != '0) begin
          rvalid_nxt = 1'b1;
          wtgt_nxt   = src_r + IDX_W'(1);
          src_nxt    = src_r - IDX_W'(1);
          remain_nxt = remain_r - CNT_W'(1);
        end
        if (rvalid_r) begin
          ram_we = 1'b1;
        end else if (remain_r == '0) begin
          ram_we         = 1'b1;
          ram_waddr      = ins_slot_r;
          ram_wdata      = {ins_addr_r[START_W-1:0], size_r};
          count_nxt      = count_r + CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          out_addr_nxt   = ins_addr_r[START_W-1:0];
          out_slot_nxt   = ins_slot_r;
          state_nxt      = S_IDLE;
        end
      end
      S_SHDN: begin
        if (remain_r != '0) begin
          rvalid_nxt = 1'b1;
          wtgt_nxt   = src_r - IDX_W'(1);
          src_nxt    = src_r + IDX_W'(1);
          remain_nxt = remain_r - CNT_W'(1);
        end
        if (rvalid_r) begin
          ram_we = 1'b1;
        end else if (remain_r == '0) begin
          count_nxt      = count_r - CNT_W'(1);
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_OK;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= BASE_RESET;
      limit_r     <= LIMIT_RESET;
      rvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rvalid_r    <= rvalid_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) begin
          base_r <= cfg_wdata;
        end else begin
          limit_r <= cfg_wdata;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r    <= in_cmd;
      addr_r   <= in_req_addr;
      size_r   <= in_req_size;
      shared_r <= in_map_shared;
      priv_r   <= in_map_private;
      fixed_r  <= in_map_fixed;
      pw_r     <= in_prot_write;
      fw_r     <= in_file_writable;
    end
    m_r          <= m_nxt;
    us_r         <= us_nxt;
    basepg_r     <= basepg_nxt;
    msz_r        <= msz_nxt;
    bound_r      <= bound_nxt;
    k_r          <= k_nxt;
    prev_start_r <= prev_start_nxt;
    prev_end_r   <= prev_end_nxt;
    tat_done_r   <= tat_done_nxt;
    tat_found_r  <= tat_found_nxt;
    tat_slot_r   <= tat_slot_nxt;
    ff_done_r    <= ff_done_nxt;
    ff_slot_r    <= ff_slot_nxt;
    ff_addr_r    <= ff_addr_nxt;
    hit_r        <= hit_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_len_r    <= hit_len_nxt;
    ins_addr_r   <= ins_addr_nxt;
    ins_slot_r   <= ins_slot_nxt;
    remain_r     <= remain_nxt;
    src_r        <= src_nxt;
    wtgt_r       <= wtgt_nxt;
    out_status_r <= out_status_nxt;
    out_addr_r   <= out_addr_nxt;
    out_slot_r   <= out_slot_nxt;
  end

`ifndef SYNTH
  a_result_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(busy))
    else $error("result without a request in flight");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_REGIONS))
    else $error("region count above table limit");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (k_r <= count_r))
    else $error("scan past the last region");
`endif

endmodule

FILE: sv/rmta_ram.sv
// ----------------------------------------------------------------------------
// rmta_ram
// Generic single write, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module rmta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mapped region table allocator. Requests are
// queued by a generator that looks at the predicted table, sent in bursts,
// and each result is checked against an in-bench table predictor. The run
// walks through several base and limit settings, extremes included.
// ----------------------------------------------------------------------------
module tb_top;
  import rmta_pkg::*;

  localparam int       WATCHDOG = 20000;
  localparam longint   PG       = longint'(1) << PAGE_BITS;

  typedef struct {
    logic        cmd;
    logic [31:0] addr;
    logic [30:0] size;
    logic        sh, pr, fx, pw, fw;
  } req_t;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [4:0]  slot;
  } res_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        in_cmd = 1'b0;
  logic [31:0] in_req_addr = '0;
  logic [30:0] in_req_size = '0;
  logic        in_map_shared = 1'b0;
  logic        in_map_private = 1'b0;
  logic        in_map_fixed = 1'b0;
  logic        in_prot_write = 1'b0;
  logic        in_file_writable = 1'b0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [31:0] out_region_addr;
  logic [4:0]  out_slot;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = '0;

  req_t        pending_reqs[$];
  res_t        expected_results[$];
  req_t        in_flight;
  int          errors = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;

  logic [63:0] tbl_start[DEPTH];
  logic [63:0] tbl_len[DEPTH];
  int          tbl_cnt = 0;
  logic [63:0] cur_base = 64'h4000_0000;
  logic [63:0] cur_limit = 64'h8000_0000;

  mmap_region_table_allocator_unit u_dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] page_ceil(logic [63:0] x);
    return (x + PG - 1) & ~(PG - 1);
  endfunction

  function automatic int insert_after(int after, logic [63:0] a, logic [63:0] sz);
    int at = after + 1;
    if (page_ceil(a + sz) >= cur_limit || at < 0 || at >= DEPTH || tbl_cnt >= DEPTH)
      return -1;
    for (int j = tbl_cnt; j > at; j--) begin
      tbl_start[j] = tbl_start[j-1];
      tbl_len[j]   = tbl_len[j-1];
    end
    tbl_start[at] = a;
    tbl_len[at]   = sz;
    return at;
  endfunction

  function automatic int place_at_hint(logic [63:0] a, logic [63:0] sz);
    int n = tbl_cnt;
    logic [63:0] m = page_ceil(a);
    logic [63:0] s, e;
    if (n == 0) return -1;
    if (m > page_ceil(tbl_start[n-1] + tbl_len[n-1])) return insert_after(n - 1, m, sz);
    for (int i = 0; i < n - 1; i++) begin
      if (tbl_start[i] >= m) return -1;
      s = page_ceil(tbl_start[i] + tbl_len[i]);
      e = page_ceil(tbl_start[i+1]);
      if (m > s && e > m + sz) return insert_after(i, m, sz);
    end
    return -1;
  endfunction

  function automatic int place_first_fit(logic [63:0] sz);
    int n = tbl_cnt;
    int i = 0;
    logic [63:0] s, e, a;
    if (n == 0) return insert_after(-1, page_ceil(cur_base), sz);
    while (i < n - 1) begin
      s = page_ceil(tbl_start[i] + tbl_len[i]);
      e = page_ceil(tbl_start[i+1]);
      if (e > s && e - s > sz) break;
      i++;
    end
    a = page_ceil(tbl_start[i] + tbl_len[i]);
    if (a + sz > cur_limit) return -1;
    return insert_after(i, a, sz);
  endfunction

  function automatic res_t table_update(req_t r);
    res_t o = '{ST_BADARG, 32'd0, 5'd0};
    logic [63:0] a = 64'(r.addr);
    logic [63:0] sz = 64'(r.size);
    logic [63:0] us;
    int n = tbl_cnt;
    int i;
    if (r.cmd == CMD_UNMAP) begin
      a  = page_ceil(a);
      us = page_ceil(sz);
      for (i = 0; i < n; i++)
        if (tbl_start[i] == a) break;
      if (i >= n || tbl_len[i] == 0) begin
        o.status = ST_NOTFOUND;
        return o;
      end
      if (tbl_len[i] <= us) begin
        for (int j = i; j < n - 1; j++) begin
          tbl_start[j] = tbl_start[j+1];
          tbl_len[j]   = tbl_len[j+1];
        end
        tbl_start[n-1] = 0;
        tbl_len[n-1]   = 0;
        tbl_cnt = n - 1;
      end else begin
        tbl_len[i] -= us;
      end
      o.status = ST_OK;
      o.slot   = i[4:0];
      return o;
    end
    if (!r.pr && !r.sh) return o;
    if (tbl_cnt >= MAX_REGIONS) begin
      o.status = ST_FULL;
      return o;
    end
    if (r.sh && r.pw && !r.fw) return o;
    if (r.fx) begin
      if (a == 0) return o;
      if (a < cur_base || page_ceil(page_ceil(a) + sz) > cur_limit || (a & (PG - 1)) != 0)
        return o;
      i = place_at_hint(a, sz);
    end else begin
      i = -1;
      if (a != 0) begin
        if (a < cur_base || page_ceil(page_ceil(a) + sz) > cur_limit) return o;
        i = place_at_hint(a, sz);
      end
      if (i < 0) i = place_first_fit(sz);
    end
    if (i < 0) begin
      o.status = ST_NOROOM;
      return o;
    end
    tbl_cnt = n + 1;
    o = '{ST_OK, tbl_start[i][31:0], i[4:0]};
    return o;
  endfunction

  function automatic req_t mk(logic cmd, logic [31:0] addr, logic [30:0] size,
                              logic sh, logic pr, logic fx, logic pw, logic fw);
    req_t r;
    r = '{cmd, addr, size, sh, pr, fx, pw, fw};
    return r;
  endfunction

  function automatic logic [30:0] rand_size();
    case ($urandom_range(0, 9))
      0: return 31'($urandom);
      1: return '0;
      2: return 31'($urandom_range(1, 4) * PG);
      default: return 31'($urandom_range(1, 16 * 4096));
    endcase
  endfunction

  function automatic logic [31:0] rand_addr(bit for_unmap);
    int k = (tbl_cnt > 0) ? $urandom_range(0, tbl_cnt - 1) : 0;
    logic [63:0] a;
    case ($urandom_range(0, for_unmap ? 3 : 5))
      0, 1: a = (tbl_cnt > 0) ? tbl_start[k] - $urandom_range(0, 1) * $urandom_range(0, 4095)
                              : cur_base;
      2: a = 64'($urandom);
      3: a = page_ceil(tbl_start[k] + tbl_len[k]) + $urandom_range(0, 3) * PG
             + $urandom_range(0, 1) * $urandom_range(0, 4095);
      4: a = cur_base + $urandom_range(0, 64) * PG;
      default: a = 0;
    endcase
    return a[31:0];
  endfunction

  function automatic req_t rand_request();
    req_t r;
    r.cmd = ($urandom_range(0, 99) < 40) ? CMD_UNMAP : CMD_MAP;
    r.addr = rand_addr(r.cmd == CMD_UNMAP);
    r.size = rand_size();
    r.sh = 1'($urandom_range(0, 1));
    r.pr = ($urandom_range(0, 9) == 0) ? 1'b0 : (r.sh ? 1'($urandom_range(0, 1)) : 1'b1);
    r.fx = ($urandom_range(0, 9) < 3);
    r.pw = 1'($urandom_range(0, 1));
    r.fw = ($urandom_range(0, 3) != 0);
    if (r.fx && $urandom_range(0, 3) != 0) r.addr[PAGE_BITS-1:0] = '0;
    return r;
  endfunction

  // request driver, bursts with random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results.push_back(table_update(in_flight));
      if (start && busy) begin
      end else if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_reqs.size() > 0) begin
        in_flight = pending_reqs.pop_front();
        in_cmd           <= in_flight.cmd;
        in_req_addr      <= in_flight.addr;
        in_req_size      <= in_flight.size;
        in_map_shared    <= in_flight.sh;
        in_map_private   <= in_flight.pr;
        in_map_fixed     <= in_flight.fx;
        in_prot_write    <= in_flight.pw;
        in_file_writable <= in_flight.fw;
        start <= 1'b1;
        if (burst_left == 0) begin
          burst_left <= $urandom_range(0, 20);
          gap_left   <= ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 40);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // result monitor
  always @(posedge clk) begin
    res_t x;
    if (rst_n && out_valid) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result status %0d", out_status);
        errors++;
      end else begin
        x = expected_results.pop_front();
        if (out_status !== x.status) begin
          $error("status expected %0d actual %0d", x.status, out_status);
          errors++;
        end
        if (out_region_addr !== x.addr) begin
          $error("region_addr expected %h actual %h", x.addr, out_region_addr);
          errors++;
        end
        if (out_slot !== x.slot) begin
          $error("slot expected %0d actual %0d", x.slot, out_slot);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
        $display("tb_top: done, errors");
        $finish;
      end
    end
  end

  task automatic wait_drained();
    while (pending_reqs.size() > 0 || start || expected_results.size() > 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic set_limits(logic [31:0] base, logic [31:0] limit);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_BASE;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_index <= CFG_LIMIT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_base  = 64'(base);
    cur_limit = 64'(limit);
  endtask

  task automatic run_random(int count);
    int made = 0;
    while (made < count) begin
      @(posedge clk);
      if (pending_reqs.size() < 2) begin
        pending_reqs.push_back(rand_request());
        made++;
      end
    end
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < DEPTH; i++) begin
      tbl_start[i] = 0;
      tbl_len[i]   = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    // directed corner cases
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h4000_0000, 31'h1000, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h1000, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h1000, 1, 0, 0, 1, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h1000, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_0000, 31'h1000, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_2000, 31'h1000, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h0, 1, 1, 0, 1, 1));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h1000, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_8000, 31'h2000, 0, 1, 1, 1, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_4800, 31'h800, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_0800, 31'h1000, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h3FFF_F000, 31'h1000, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h7FFF_F000, 31'h1001, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'hFFFF_FFFF, 31'h7FFF_FFFF, 1, 1, 0, 1, 1));
    pending_reqs.push_back(mk(CMD_MAP, 32'h0, 31'h7FFF_FFFF, 0, 1, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_MAP, 32'h4000_1000, 31'h1000, 0, 1, 1, 0, 0));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h4000_8000, 31'h1000, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h3FFF_F001, 31'h7FFF_FFFF, 1, 1, 1, 1, 1));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'h4000_7FFF, 31'h1, 0, 0, 0, 0, 0));
    pending_reqs.push_back(mk(CMD_UNMAP, 32'hFFFF_FFFF, 31'h0, 0, 0, 0, 0, 0));
    wait_drained();
    run_random(400);
    set_limits(32'h0, 32'hFFFF_FFFF);
    run_random(300);
    set_limits(32'h1000_0000, 32'h2000_0000);
    run_random(300);
    set_limits(32'hFFFF_FFFF, 32'h0);
    run_random(60);
    set_limits(32'h4000_0000, 32'h8000_0000);
    run_random(370);
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
